>>> hdl/ct7_pkg.sv
`default_nettype none
package ct7_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int PIX_W        = 8;
    localparam int POS_X_W      = 10;
    localparam int POS_Y_W      = 16;
    localparam int WID_W        = 11;
    localparam int HGT_W        = 16;
    localparam int DESC_W       = 48;
    localparam int WIN          = 7;
    localparam int WIN_RAD      = 3;
    localparam int CENTER       = WIN_RAD * WIN + WIN_RAD;
    localparam int LINES        = WIN - 1;
    localparam int SLOT_W       = $clog2(LINES);
    localparam int LAG_W        = $clog2(WIN_RAD * MAX_WIDTH + WIN_RAD + 1);
    localparam int ADDR_W       = 3;
    localparam int DATA_W       = 32;
    localparam int WIDTH_RESET  = 512;
    localparam int HEIGHT_RESET = 512;

    localparam logic REG_IDX_WIDTH  = 1'b0;
    localparam logic REG_IDX_HEIGHT = 1'b1;

    typedef logic [LINES-1:0][PIX_W-1:0] line_t;

    typedef struct packed {
        logic               take;
        logic               emit;
        logic [PIX_W-1:0]   pix;
        logic [COL_W-1:0]   col;
        logic [SLOT_W-1:0]  slot;
        logic [POS_X_W-1:0] pos_x;
        logic [POS_Y_W-1:0] pos_y;
        logic               border;
        logic               last;
    } ct7_item_t;

endpackage
`default_nettype wire

>>> hdl/ct7_pixel_if.sv
`default_nettype none
interface ct7_pixel_if;
    import ct7_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;
    logic             drain;

    modport source (output valid, output pixel_value, output drain, input ready);
    modport sink (input valid, input pixel_value, input drain, output ready);
endinterface
`default_nettype wire

>>> hdl/ct7_result_if.sv
`default_nettype none
interface ct7_result_if;
    import ct7_pkg::*;

    logic               valid;
    logic               ready;
    logic [DESC_W-1:0]  descriptor;
    logic [POS_X_W-1:0] pos_x;
    logic [POS_Y_W-1:0] pos_y;
    logic               is_border;
    logic               frame_last;

    modport source (output valid, output descriptor, output pos_x, output pos_y,
                    output is_border, output frame_last, input ready);
    modport sink (input valid, input descriptor, input pos_x, input pos_y,
                  input is_border, input frame_last, output ready);
endinterface
`default_nettype wire

>>> hdl/ct7_ctrl.sv
`default_nettype none
module ct7_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    ct7_pixel_if.sink                  pixel_in,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ct7_pkg::ADDR_W-1:0] paddr,
    input  logic [ct7_pkg::DATA_W-1:0] pwdata,
    output logic [ct7_pkg::DATA_W-1:0] prdata,
    input  logic                       s1_ready,
    output logic                       push,
    output ct7_pkg::ct7_item_t         item
);
    import ct7_pkg::*;

    logic [WID_W-1:0]  width_reg, width_next;
    logic [HGT_W-1:0]  height_reg, height_next;
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [HGT_W-1:0]  in_row_reg, in_row_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [LAG_W-1:0]  cnt_reg, cnt_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [HGT_W-1:0]  out_row_reg, out_row_next;

    logic [WID_W-1:0]  w_eff;
    logic [HGT_W-1:0]  h_eff;
    logic [LAG_W-1:0]  lag;
    logic              cfg_wr;
    logic              accept;
    logic              frame_done;
    logic              take;
    logic              emit;
    logic              in_col_last;
    logic              in_row_last;
    logic              out_col_last;
    logic              out_row_last;
    logic              out_last;
    logic              border;

    assign w_eff = (width_reg == '0) ? WID_W'(1) :
                   (width_reg > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg == '0) ? HGT_W'(1) : height_reg;
    assign lag   = LAG_W'(w_eff) * LAG_W'(WIN_RAD) + LAG_W'(WIN_RAD);

    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[ADDR_W-1] == REG_IDX_HEIGHT) ? DATA_W'(height_reg)
                                                        : DATA_W'(width_reg);

    assign pixel_in.ready = s1_ready;
    assign accept         = pixel_in.valid && s1_ready;

    assign frame_done  = in_row_reg >= h_eff;
    assign take        = !frame_done && !pixel_in.drain;
    assign in_col_last = (WID_W'(in_col_reg) + WID_W'(1)) >= w_eff;
    assign in_row_last = ((HGT_W+1)'(in_row_reg) + (HGT_W+1)'(1)) >= (HGT_W+1)'(h_eff);

    assign out_col_last = (WID_W'(out_col_reg) + WID_W'(1)) >= w_eff;
    assign out_row_last = ((HGT_W+1)'(out_row_reg) + (HGT_W+1)'(1)) >= (HGT_W+1)'(h_eff);
    assign out_last     = out_col_last && out_row_last;
    assign border = (out_col_reg < COL_W'(WIN_RAD)) ||
                    ((WID_W'(out_col_reg) + WID_W'(WIN_RAD)) >= w_eff) ||
                    (out_row_reg < HGT_W'(WIN_RAD)) ||
                    (((HGT_W+1)'(out_row_reg) + (HGT_W+1)'(WIN_RAD)) >= (HGT_W+1)'(h_eff));

    // released result: after the frame every item, inside it once the lag is covered or at its last pixel
    assign emit = frame_done || (take && ((cnt_reg >= lag) || (in_col_last && in_row_last)));
    assign push = accept && (take || emit);

    always_comb
    begin
        item.take   = take;
        item.emit   = emit;
        item.pix    = pixel_in.pixel_value;
        item.col    = in_col_reg;
        item.slot   = slot_reg;
        item.pos_x  = POS_X_W'(out_col_reg);
        item.pos_y  = out_row_reg;
        item.border = border;
        item.last   = out_last;
    end

    always_comb
    begin
        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        slot_next    = slot_reg;
        cnt_next     = cnt_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_wr)
        begin
            unique case (paddr[ADDR_W-1])
                REG_IDX_WIDTH:  width_next  = pwdata[WID_W-1:0];
                REG_IDX_HEIGHT: height_next = pwdata[HGT_W-1:0];
                default:        width_next  = width_reg;
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            slot_next    = '0;
            cnt_next     = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (accept)
        begin
            if (take)
            begin
                if (cnt_reg < lag)
                begin
                    cnt_next = cnt_reg + LAG_W'(1);
                end
                if (in_col_last)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + HGT_W'(1);
                    slot_next   = (slot_reg == SLOT_W'(LINES - 1)) ? '0
                                                                   : slot_reg + SLOT_W'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
            end
            if (emit)
            begin
                if (out_last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    slot_next    = '0;
                    cnt_next     = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_col_last)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + HGT_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WID_W'(WIDTH_RESET);
            height_reg  <= HGT_W'(HEIGHT_RESET);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            slot_reg    <= '0;
            cnt_reg     <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            slot_reg    <= slot_next;
            cnt_reg     <= cnt_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/ct7_line_mem.sv
`default_nettype none
module ct7_line_mem (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ct7_pkg::ct7_item_t item0,
    input  logic               s2_ready,
    output logic               s1_ready,
    output logic               adv1,
    output ct7_pkg::ct7_item_t item1,
    output ct7_pkg::line_t     col_pix
);
    import ct7_pkg::*;

    line_t             mem [MAX_WIDTH];
    line_t             rdata_reg;
    line_t             fwd_data_reg;
    logic              fwd_reg, fwd_next;
    logic              valid1_reg, valid1_next;
    ct7_item_t         item1_reg;
    line_t             line;
    line_t             wdata;
    logic              wr_en;
    logic              rd_en;

    assign adv1     = valid1_reg && s2_ready;
    assign s1_ready = !valid1_reg || s2_ready;
    assign item1    = item1_reg;

    assign wr_en = adv1 && item1_reg.take;
    assign rd_en = push && item0.take;

    // same column written back while read again
    assign fwd_next = wr_en && (item1_reg.col == item0.col);
    assign line     = fwd_reg ? fwd_data_reg : rdata_reg;

    always_comb
    begin
        wdata = line;
        wdata[item1_reg.slot] = item1_reg.pix;
    end

    // oldest stored row first
    always_comb
    begin
        logic [SLOT_W:0] sel;
        for (int r = 0; r < LINES; r++)
        begin
            sel = (SLOT_W+1)'(item1_reg.slot) + (SLOT_W+1)'(r);
            if (sel >= (SLOT_W+1)'(LINES))
            begin
                sel = sel - (SLOT_W+1)'(LINES);
            end
            col_pix[r] = line[sel[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[item1_reg.col] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg    <= mem[item0.col];
            fwd_data_reg <= wdata;
        end
        if (push)
        begin
            item1_reg <= item0;
        end
    end

    always_comb
    begin
        valid1_next = valid1_reg;
        if (push)
        begin
            valid1_next = 1'b1;
        end
        else if (adv1)
        begin
            valid1_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            fwd_reg    <= 1'b0;
        end
        else
        begin
            valid1_reg <= valid1_next;
            if (rd_en)
            begin
                fwd_reg <= fwd_next;
            end
        end
    end

endmodule
`default_nettype wire

>>> hdl/ct7_window.sv
`default_nettype none
module ct7_window (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv1,
    input  ct7_pkg::ct7_item_t item1,
    input  ct7_pkg::line_t     col_pix,
    output logic               s2_ready,
    ct7_result_if.source       result_out
);
    import ct7_pkg::*;

    logic [PIX_W-1:0]   win_reg [WIN][WIN];
    logic               valid2_reg, valid2_next;
    ct7_item_t          item2_reg;
    logic               out_valid_reg, out_valid_next;
    logic [DESC_W-1:0]  desc_reg;
    logic [POS_X_W-1:0] pos_x_reg;
    logic [POS_Y_W-1:0] pos_y_reg;
    logic               border_reg;
    logic               last_reg;
    logic [DESC_W-1:0]  census;
    logic               load2;
    logic               adv2;

    assign load2    = adv1 && item1.emit;
    assign adv2     = valid2_reg && (!out_valid_reg || result_out.ready);
    assign s2_ready = !valid2_reg || adv2;

    always_ff @(posedge clk)
    begin
        if (adv1 && item1.take)
        begin
            for (int r = 0; r < WIN; r++)
            begin
                for (int c = 0; c < WIN - 1; c++)
                begin
                    win_reg[r][c] <= win_reg[r][c+1];
                end
            end
            for (int r = 0; r < LINES; r++)
            begin
                win_reg[r][WIN-1] <= col_pix[r];
            end
            win_reg[WIN-1][WIN-1] <= item1.pix;
        end
    end

    always_comb
    begin
        census = '0;
        for (int r = 0; r < WIN; r++)
        begin
            for (int c = 0; c < WIN; c++)
            begin
                if (r * WIN + c < CENTER)
                begin
                    census[r*WIN+c] = win_reg[WIN_RAD][WIN_RAD] <= win_reg[r][c];
                end
                else if (r * WIN + c > CENTER)
                begin
                    census[r*WIN+c-1] = win_reg[WIN_RAD][WIN_RAD] <= win_reg[r][c];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            item2_reg <= item1;
        end
        if (adv2)
        begin
            desc_reg   <= item2_reg.border ? '0 : census;
            pos_x_reg  <= item2_reg.pos_x;
            pos_y_reg  <= item2_reg.pos_y;
            border_reg <= item2_reg.border;
            last_reg   <= item2_reg.last;
        end
    end

    always_comb
    begin
        valid2_next = valid2_reg;
        if (load2)
        begin
            valid2_next = 1'b1;
        end
        else if (adv2)
        begin
            valid2_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (adv2)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid2_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid2_reg    <= valid2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_out.valid      = out_valid_reg;
    assign result_out.descriptor = desc_reg;
    assign result_out.pos_x      = pos_x_reg;
    assign result_out.pos_y      = pos_y_reg;
    assign result_out.is_border  = border_reg;
    assign result_out.frame_last = last_reg;

endmodule
`default_nettype wire

>>> hdl/census_transform_7x7_unit.sv
// path: the request that releases a result moves through the stage-1 and stage-2 item registers
// into the output register; that request lags the result's own pixel by three rows and three pixels
// throughput: one request per cycle while the output side does not stall, set by the read-modify-write
// of one six-row column word of the line memory per pixel
// reset: positions cleared, width and height 512; line memory and window not cleared
`default_nettype none
module census_transform_7x7_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    ct7_pixel_if.sink                  pixel_in,
    ct7_result_if.source               result_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ct7_pkg::ADDR_W-1:0] paddr,
    input  logic [ct7_pkg::DATA_W-1:0] pwdata,
    output logic [ct7_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import ct7_pkg::*;

    logic      push;
    ct7_item_t item0;
    ct7_item_t item1;
    logic      s1_ready;
    logic      s2_ready;
    logic      adv1;
    line_t     col_pix;

    assign pready = 1'b1;

    ct7_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel_in (pixel_in),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .s1_ready (s1_ready),
        .push     (push),
        .item     (item0)
    );

    ct7_line_mem u_line_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item0    (item0),
        .s2_ready (s2_ready),
        .s1_ready (s1_ready),
        .adv1     (adv1),
        .item1    (item1),
        .col_pix  (col_pix)
    );

    ct7_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv1       (adv1),
        .item1      (item1),
        .col_pix    (col_pix),
        .s2_ready   (s2_ready),
        .result_out (result_out)
    );

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_in.ready |-> (result_out.valid && !result_out.ready))
        else $error("input stalled while output side can move");

    a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.is_border) |-> (result_out.descriptor == '0))
        else $error("border result with nonzero descriptor");

    a_inner_position: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && !result_out.is_border) |->
        ((result_out.pos_x >= POS_X_W'(WIN_RAD)) && (result_out.pos_y >= POS_Y_W'(WIN_RAD))))
        else $error("inner result too close to the top or left edge");

endmodule
`default_nettype wire
